FILE: hdl/rme_pkg.sv
// Shared definitions for the register machine executor.
// Opcodes, field widths and default sizes; no dependencies.
package rme_pkg;

   localparam int unsigned REG_COUNT     = 32;
   localparam int unsigned REG_IDX_W     = 5;
   localparam int unsigned WORD_W        = 32;
   localparam int unsigned BYTE_W        = 8;
   localparam int unsigned LANES         = 4;
   localparam int unsigned PROG_SIZE_W   = 17;
   localparam int unsigned DEF_MEM_BYTES = 131072;

   typedef enum logic [4:0] {
      OP_NOP = 5'd0,
      OP_ADD = 5'd1,
      OP_SUB = 5'd2,
      OP_AND = 5'd3,
      OP_OR  = 5'd4,
      OP_XOR = 5'd5,
      OP_NOT = 5'd6,
      OP_LSH = 5'd7,
      OP_ASH = 5'd8,
      OP_TCU = 5'd9,
      OP_TCS = 5'd10,
      OP_SET = 5'd11,
      OP_MOV = 5'd12,
      OP_LDW = 5'd13,
      OP_STW = 5'd14,
      OP_LDB = 5'd15,
      OP_STB = 5'd16,
      OP_BRK = 5'd17
   } opcode_type;

endpackage

FILE: hdl/rme_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Read during a write to the same address returns the old contents; no dependencies.
module rme_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

FILE: hdl/rme_alu.sv
// Register-to-register datapath: arithmetic, logic, shifts, compares, SET, MOV.
// Uses opcode_type and widths from rme_pkg.
module rme_alu
   import rme_pkg::*;
(
   input  opcode_type        command,
   input  logic [WORD_W-1:0] operand_b,
   input  logic [WORD_W-1:0] operand_c,
   input  logic [BYTE_W-1:0] imm_low,
   input  logic [BYTE_W-1:0] imm_high,
   output logic [WORD_W-1:0] result
);

   logic              shift_left;
   logic [WORD_W-1:0] magnitude;
   logic [WORD_W-1:0] left_val;
   logic [WORD_W-1:0] lright_val;
   logic [WORD_W-1:0] aright_val;
   logic              sign_b;
   logic [WORD_W-1:0] tcu_val;
   logic [WORD_W-1:0] tcs_val;

   always_comb begin
      // positive amount shifts left; zero or negative shifts right by magnitude
      shift_left = (operand_c != '0) && !operand_c[WORD_W-1];
      magnitude  = '0 - operand_c;
      sign_b     = operand_b[WORD_W-1];
      left_val   = (operand_c >= WORD_W) ? '0 : (operand_b << operand_c[4:0]);
      lright_val = (magnitude >= WORD_W) ? '0 : (operand_b >> magnitude[4:0]);
      aright_val = (magnitude >= WORD_W) ? {WORD_W{sign_b}}
                 : WORD_W'($signed(operand_b) >>> magnitude[4:0]);

      if (operand_b > operand_c) begin
         tcu_val = WORD_W'(1);
      end else if (operand_b < operand_c) begin
         tcu_val = '1;
      end else begin
         tcu_val = '0;
      end

      if ($signed(operand_b) > $signed(operand_c)) begin
         tcs_val = WORD_W'(1);
      end else if ($signed(operand_b) < $signed(operand_c)) begin
         tcs_val = '1;
      end else begin
         tcs_val = '0;
      end
   end

   always_comb begin
      case (command)
         OP_ADD: result = operand_b + operand_c;
         OP_SUB: result = operand_b - operand_c;
         OP_AND: result = operand_b & operand_c;
         OP_OR:  result = operand_b | operand_c;
         OP_XOR: result = operand_b ^ operand_c;
         OP_NOT: result = ~operand_b;
         OP_LSH: result = shift_left ? left_val : lright_val;
         OP_ASH: result = shift_left ? left_val : aright_val;
         OP_TCU: result = tcu_val;
         OP_TCS: result = tcs_val;
         OP_SET: result = {{(WORD_W-2*BYTE_W){1'b0}}, imm_high, imm_low};
         OP_MOV: result = operand_b;
         default: result = '0;
      endcase
   end

endmodule

FILE: hdl/register_machine_executor.sv
// Register machine executor: top level, three-stage pipeline around RAMs.
// Depends on rme_pkg, rme_ram (register file copies, data memory lanes), rme_alu.
//
//   channel | ports                                   | direction
//   req     | req_valid/req_ready, command, fields    | in, one instruction per transfer
//   rsp     | rsp_valid/rsp_ready, seven result ports | out, one result per instruction
//   csr     | csr_write_enable, csr_write_data        | in, program_size, no wait
//
// One instruction per cycle sustained while rsp_ready is high and no clear runs.
// Stage 1 reads the register file RAMs (forwarded), stage 2 has the
// data memory read word for loads and commits registers, then the output register.
// After reset the data memory is cleared, one row of four byte lanes per cycle, with
// req_ready low. rsp_ready low stalls the pipeline back to req_ready within the same cycle.
module register_machine_executor
   import rme_pkg::*;
#(
   parameter int unsigned MEM_BYTES = DEF_MEM_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [4:0]             req_command,
   input  logic [7:0]             req_field_a,
   input  logic [7:0]             req_field_b,
   input  logic [7:0]             req_field_c,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_wrote_register,
   output logic [REG_IDX_W-1:0]   rsp_dest_index,
   output logic [WORD_W-1:0]      rsp_dest_value,
   output logic                   rsp_wrote_memory,
   output logic                   rsp_bad_address,
   output logic                   rsp_halted,
   output logic [WORD_W-1:0]      rsp_program_counter,
   input  logic                   csr_write_enable,
   input  logic [PROG_SIZE_W-1:0] csr_write_data
);

   localparam int unsigned BANK_DEPTH = (MEM_BYTES + LANES - 1) / LANES;
   localparam int unsigned ROW_W      = $clog2(BANK_DEPTH);
   localparam logic [WORD_W-1:0] LAST_WORD_ADDR = WORD_W'(MEM_BYTES - LANES);
   localparam logic [WORD_W-1:0] MEM_LIMIT      = WORD_W'(MEM_BYTES);
   localparam logic [ROW_W-1:0]  LAST_ROW       = ROW_W'(BANK_DEPTH - 1);
   localparam int unsigned SP_W = PROG_SIZE_W + 1;
   localparam logic [REG_IDX_W-1:0] PC_REG = REG_IDX_W'(0);
   localparam logic [REG_IDX_W-1:0] SP_REG = REG_IDX_W'(REG_COUNT - 1);

   typedef struct packed {
      opcode_type           command;
      logic [REG_IDX_W-1:0] ra;
      logic [7:0]           fb;
      logic [7:0]           fc;
   } stage1_type;

   typedef struct packed {
      logic                  wr;
      logic [REG_IDX_W-1:0]  ra;
      logic [WORD_W-1:0]     res;
      logic                  ld_w;
      logic                  ld_b;
      logic [WORD_W-BYTE_W-1:0] va_hi;
      logic [1:0]            off;
      logic                  wm;
      logic                  bad;
      logic                  halt;
      logic [WORD_W-1:0]     pc_seen;
   } stage2_type;

   // control
   logic                   clear_ff, clear_in;
   logic [ROW_W-1:0]       clr_cnt_ff, clr_cnt_in;
   logic                   started_ff;
   logic [PROG_SIZE_W-1:0] prog_size_ff;
   logic [SP_W-1:0]        sp_ff;
   logic [WORD_W-1:0]      pc_ff;
   logic [REG_COUNT-1:0]   rf_valid_ff;
   logic                   s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   stage1_type             s1_ff;
   stage2_type             s2_ff, s2_in;
   logic [ROW_W-1:0]       s2_rows_ff [LANES];

   // last register commit, not yet visible at the RAM read port
   logic                   rec_we_ff;
   logic [REG_IDX_W-1:0]   rec_idx_ff;
   logic [WORD_W-1:0]      rec_val_ff;

   logic accept, adv1, adv2;

   // register file copies: one per operand
   logic [REG_IDX_W-1:0] rf_raddr_a, rf_raddr_b, rf_raddr_c;
   logic [WORD_W-1:0]    rf_rdata_a, rf_rdata_b, rf_rdata_c;
   logic                 rf_we;

   logic [WORD_W-1:0] va, vb, vc;
   logic [WORD_W-1:0] s2_res, s2_pc_out, pc_fwd, pc_seen;
   logic [WORD_W-1:0] alu_res;
   logic [WORD_W-1:0] mem_addr;
   logic [ROW_W-1:0]  base_row;
   logic [1:0]        off;
   logic              fits_w, fits_b;
   logic              st_w, st_b;
   logic [ROW_W-1:0]  lane_row [LANES];

   logic              mem_we    [LANES];
   logic [ROW_W-1:0]  mem_waddr [LANES];
   logic [BYTE_W-1:0] mem_wdata [LANES];
   logic [ROW_W-1:0]  mem_raddr [LANES];
   logic [BYTE_W-1:0] mem_rdata [LANES];
   logic [WORD_W-1:0] load_word;

   logic [REG_IDX_W-1:0] s1_rb, s1_rc;

   assign s1_rb = s1_ff.fb[REG_IDX_W-1:0];
   assign s1_rc = s1_ff.fc[REG_IDX_W-1:0];

   // pipeline flow
   assign adv2      = s2_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign adv1      = s1_valid_ff && (!s2_valid_ff || adv2);
   assign req_ready = !clear_ff && (!s1_valid_ff || adv1);
   assign accept    = req_valid && req_ready;

   // register file read: new item on transfer, else re-read for the held item
   assign rf_raddr_a = accept ? req_field_a[REG_IDX_W-1:0] : s1_ff.ra;
   assign rf_raddr_b = accept ? req_field_b[REG_IDX_W-1:0] : s1_rb;
   assign rf_raddr_c = accept ? req_field_c[REG_IDX_W-1:0] : s1_rc;
   assign rf_we      = adv2 && s2_ff.wr;

   rme_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_a (
      .clock(clock), .write_enable(rf_we), .write_address(s2_ff.ra),
      .write_data(s2_res), .read_address(rf_raddr_a), .read_data(rf_rdata_a));
   rme_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_b (
      .clock(clock), .write_enable(rf_we), .write_address(s2_ff.ra),
      .write_data(s2_res), .read_address(rf_raddr_b), .read_data(rf_rdata_b));
   rme_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_c (
      .clock(clock), .write_enable(rf_we), .write_address(s2_ff.ra),
      .write_data(s2_res), .read_address(rf_raddr_c), .read_data(rf_rdata_c));

   // stage 2 final values
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         load_word[k*BYTE_W +: BYTE_W] = mem_rdata[2'(s2_ff.off + 2'(k))];
      end
      if (s2_ff.ld_w) begin
         s2_res = load_word;
      end else if (s2_ff.ld_b) begin
         s2_res = {s2_ff.va_hi, load_word[BYTE_W-1:0]};
      end else begin
         s2_res = s2_ff.res;
      end
      s2_pc_out = (s2_ff.wr && s2_ff.ra == PC_REG) ? s2_res : s2_ff.pc_seen;
   end

   assign pc_fwd  = s2_valid_ff ? s2_pc_out : pc_ff;
   assign pc_seen = pc_fwd + WORD_W'(4);

   // operand with forwarding: PC, pending commit, last commit, RAM, reset value
   function automatic logic [WORD_W-1:0] read_operand(input logic [REG_IDX_W-1:0] idx,
                                                       input logic [WORD_W-1:0] ram_val);
      logic [WORD_W-1:0] value;
      if (idx == PC_REG) begin
         value = pc_seen;
      end else if (s2_valid_ff && s2_ff.wr && s2_ff.ra == idx) begin
         value = s2_res;
      end else if (rec_we_ff && rec_idx_ff == idx) begin
         value = rec_val_ff;
      end else if (rf_valid_ff[idx]) begin
         value = ram_val;
      end else if (idx == SP_REG) begin
         value = WORD_W'(sp_ff);
      end else begin
         value = '0;
      end
      return value;
   endfunction

   always_comb begin
      va = read_operand(s1_ff.ra, rf_rdata_a);
      vb = read_operand(s1_rb, rf_rdata_b);
      vc = read_operand(s1_rc, rf_rdata_c);
   end

   rme_alu u_alu (
      .command  (s1_ff.command),
      .operand_b(vb),
      .operand_c(vc),
      .imm_low  (s1_ff.fb),
      .imm_high (s1_ff.fc),
      .result   (alu_res)
   );

   // stage 1 decode and address check
   always_comb begin
      mem_addr = (s1_ff.command == OP_LDW || s1_ff.command == OP_LDB) ? vb : va;
      fits_w   = mem_addr <= LAST_WORD_ADDR;
      fits_b   = mem_addr < MEM_LIMIT;
      off      = mem_addr[1:0];
      base_row = mem_addr[ROW_W+1:2];
      st_w     = 1'b0;
      st_b     = 1'b0;

      s2_in         = '0;
      s2_in.ra      = s1_ff.ra;
      s2_in.va_hi   = va[WORD_W-1:BYTE_W];
      s2_in.off     = off;
      s2_in.pc_seen = pc_seen;

      case (s1_ff.command)
         OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_NOT, OP_LSH, OP_ASH,
         OP_TCU, OP_TCS, OP_SET, OP_MOV: begin
            s2_in.wr  = 1'b1;
            s2_in.res = alu_res;
         end
         OP_LDW: begin
            s2_in.wr   = fits_w;
            s2_in.ld_w = fits_w;
            s2_in.bad  = !fits_w;
         end
         OP_LDB: begin
            s2_in.wr   = fits_b;
            s2_in.ld_b = fits_b;
            s2_in.bad  = !fits_b;
         end
         OP_STW: begin
            st_w      = fits_w;
            s2_in.wm  = fits_w;
            s2_in.bad = !fits_w;
         end
         OP_STB: begin
            st_b      = fits_b;
            s2_in.wm  = fits_b;
            s2_in.bad = !fits_b;
         end
         OP_BRK: begin
            s2_in.halt = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // data memory lanes: lane j holds bytes whose address mod 4 is j
   always_comb begin
      logic [1:0] k;
      for (int j = 0; j < LANES; j++) begin
         k           = 2'(j) - off;
         lane_row[j] = base_row + ROW_W'(2'(j) < off);
         if (clear_ff) begin
            mem_we[j]    = 1'b1;
            mem_waddr[j] = clr_cnt_ff;
            mem_wdata[j] = '0;
         end else begin
            mem_we[j]    = adv1 && (st_w || (st_b && 2'(j) == off));
            mem_waddr[j] = lane_row[j];
            mem_wdata[j] = st_w ? BYTE_W'(vb >> {k, 3'b000}) : vb[BYTE_W-1:0];
         end
         // hold the read for a stalled load
         mem_raddr[j] = adv1 ? lane_row[j] : s2_rows_ff[j];
      end
   end

   for (genvar j = 0; j < LANES; j++) begin : g_lane
      rme_ram #(.WIDTH(BYTE_W), .DEPTH(BANK_DEPTH)) u_mem (
         .clock        (clock),
         .write_enable (mem_we[j]),
         .write_address(mem_waddr[j]),
         .write_data   (mem_wdata[j]),
         .read_address (mem_raddr[j]),
         .read_data    (mem_rdata[j])
      );
   end

   // clearing pass
   always_comb begin
      clear_in   = clear_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clear_ff) begin
         if (clr_cnt_ff == LAST_ROW) begin
            clear_in = 1'b0;
         end else begin
            clr_cnt_in = clr_cnt_ff + ROW_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clr_cnt_ff   <= '0;
         started_ff   <= 1'b0;
         prog_size_ff <= '0;
         pc_ff        <= '0;
         rf_valid_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rec_we_ff    <= 1'b0;
      end else begin
         clear_ff   <= clear_in;
         clr_cnt_ff <= clr_cnt_in;
         if (csr_write_enable) begin
            prog_size_ff <= csr_write_data;
         end
         if (accept) begin
            started_ff <= 1'b1;
         end
         if (accept || adv1) begin
            s1_valid_ff <= accept;
         end
         if (adv1 || adv2) begin
            s2_valid_ff <= adv1;
         end
         if (adv2) begin
            rsp_valid_ff <= 1'b1;
            pc_ff        <= s2_pc_out;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         rec_we_ff <= rf_we;
         if (rf_we) begin
            rf_valid_ff[s2_ff.ra] <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept && !started_ff) begin
         sp_ff <= SP_W'(prog_size_ff) + SP_W'(4);
      end
      if (accept) begin
         s1_ff.command <= opcode_type'(req_command);
         s1_ff.ra      <= req_field_a[REG_IDX_W-1:0];
         s1_ff.fb      <= req_field_b;
         s1_ff.fc      <= req_field_c;
      end
      if (adv1) begin
         s2_ff      <= s2_in;
         s2_rows_ff <= lane_row;
      end
      rec_idx_ff <= s2_ff.ra;
      rec_val_ff <= s2_res;
      if (adv2) begin
         rsp_wrote_register  <= s2_ff.wr;
         rsp_dest_index      <= s2_ff.wr ? s2_ff.ra : '0;
         rsp_dest_value      <= s2_ff.wr ? s2_res : '0;
         rsp_wrote_memory    <= s2_ff.wm;
         rsp_bad_address     <= s2_ff.bad;
         rsp_halted          <= s2_ff.halt;
         rsp_program_counter <= s2_pc_out;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_no_transfer_in_clear: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !clear_ff)
      else $error("instruction taken during memory clear");

   a_stage2_holds: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !adv2 |=> s2_valid_ff && $stable(s2_ff.pc_seen))
      else $error("stalled stage 2 lost its instruction");

   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_wrote_register |-> rsp_dest_index == '0 && rsp_dest_value == '0)
      else $error("destination fields set without register write");

   a_halt_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_halted |->
         !rsp_wrote_register && !rsp_wrote_memory && !rsp_bad_address)
      else $error("halt result carries other effects");
`endif

endmodule
